>>> sv/ixpe_pkg.sv
// Shared types, codes and pixel conversion for the palette expander.
package ixpe_pkg;

  localparam int unsigned ROW_ENTRIES = 16;

  // Request function codes
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_PIXEL = 1'b1;

  // Pixel mode register codes
  localparam logic [1:0] MODE_RGB555 = 2'd0;
  localparam logic [1:0] MODE_RAW4   = 2'd1;
  localparam logic [1:0] MODE_PAL4   = 2'd2;

  // Configuration register indexes
  localparam logic CFG_PIXEL_MODE  = 1'b0;
  localparam logic CFG_PALETTE_ROW = 1'b1;

  typedef enum logic [1:0] {
    KIND_DIRECT,
    KIND_RAW,
    KIND_PALETTE
  } kind_e;

  // One pixel on its way from the sequencer to the output stage
  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;  // RGB555 word, or raw nibble in bits 3:0
    logic        zero;   // palette row out of range: reads as zero
    logic        last;
    logic        done;
  } pix_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } rgba_t;

  function automatic rgba_t rgb555_to_rgba(logic [15:0] v);
    rgba_t c;
    c.red   = {v[4:0], 3'b000};
    c.green = {v[9:5], 3'b000};
    c.blue  = {v[14:10], 3'b000};
    c.alpha = (v == 16'h0000) ? 8'h00 : 8'hFF;
    return c;
  endfunction

  function automatic rgba_t raw_to_rgba(logic [3:0] n);
    rgba_t c;
    c.red   = {4'h0, n};
    c.green = {4'h0, n};
    c.blue  = {4'h0, n};
    c.alpha = {4'h0, n};
    return c;
  endfunction

endpackage

>>> sv/indexed_pixel_palette_expander_unit.sv
// Top level of the indexed pixel palette expander.
//
// Requests arrive on in_valid_i/in_ready_o. A load request (func 0) writes
// data_word_i into the palette memory at entry_address_i and gives no pixel.
// A pixel request gives one pixel in 16bpp mode, two pixels (low nibble
// first) in the 4bpp modes and none in the unused mode code 3; pixels leave on
// out_valid_o/out_ready_i, one per cycle while the receiver is ready.
// Configuration writes use cfg_valid_i/cfg_ready_o and are always taken;
// the user must make them only while the block is idle (not enforced).
// A pixel passes the request register (loaded at the accepting edge), the
// pixel register with the palette read, and the output register.
// Throughput: one pixel per cycle while the receiver is ready; the request
// register takes a new request as it issues the last pixel of the one it
// holds, matching the one-pixel output channel and one memory access a cycle.
// When the receiver stalls, the output register holds, the pixel register
// behind it fills, and the request register then stops taking requests; the
// memory read data holds with its pixel. Reset clears all valid flags and
// the mode and row registers; the palette memory is not cleared and must be
// loaded before it is used.
module indexed_pixel_palette_expander_unit #(
  parameter int unsigned PALETTE_ROWS = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [6:0]  cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        func_i,
  input  logic [15:0] data_word_i,
  input  logic [10:0] entry_address_i,
  input  logic        end_of_image_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [7:0]  alpha_o,
  output logic        last_of_item_o,
  output logic        image_done_o
);
  import ixpe_pkg::*;

  localparam int unsigned DEPTH = PALETTE_ROWS * ROW_ENTRIES;
  localparam int unsigned AW    = $clog2(DEPTH);

  // configuration registers
  logic [1:0] mode_q;
  logic [6:0] row_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RGB555;
      row_q  <= 7'd0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_PIXEL_MODE:  mode_q <= cfg_data_i[1:0];
        CFG_PALETTE_ROW: row_q  <= cfg_data_i;
        default: begin
          mode_q <= mode_q;
        end
      endcase
    end
  end

  // sequencer and palette memory
  logic          pix_valid;
  pix_t          pix;
  logic          b_ready;
  logic          mem_we;
  logic          mem_re;
  logic [AW-1:0] mem_addr;
  logic [15:0]   mem_wdata;
  logic [15:0]   mem_rdata;

  ixpe_sequencer #(
    .PALETTE_ROWS (PALETTE_ROWS),
    .DEPTH        (DEPTH),
    .AW           (AW)
  ) u_seq (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .func_i          (func_i),
    .data_word_i     (data_word_i),
    .entry_address_i (entry_address_i),
    .end_of_image_i  (end_of_image_i),
    .mode_i          (mode_q),
    .row_i           (row_q),
    .pix_ready_i     (b_ready),
    .pix_valid_o     (pix_valid),
    .pix_o           (pix),
    .mem_we_o        (mem_we),
    .mem_re_o        (mem_re),
    .mem_addr_o      (mem_addr),
    .mem_wdata_o     (mem_wdata)
  );

  ixpe_palette_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .re_i    (mem_re),
    .addr_i  (mem_addr),
    .wdata_i (mem_wdata),
    .rdata_o (mem_rdata)
  );

  // pixel register, aligned with the memory read data
  logic  b_valid_q;
  pix_t  b_pix_q;
  logic  c_free;
  rgba_t color;

  assign c_free  = !out_valid_o || out_ready_i;
  assign b_ready = !b_valid_q || c_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (b_ready) begin
      b_valid_q <= pix_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_ready && pix_valid) begin
      b_pix_q <= pix;
    end
  end

  // color conversion between pixel and output registers
  always_comb begin
    case (b_pix_q.kind)
      KIND_RAW:     color = raw_to_rgba(b_pix_q.value[3:0]);
      KIND_PALETTE: color = rgb555_to_rgba(b_pix_q.zero ? 16'h0000 : mem_rdata);
      default:      color = rgb555_to_rgba(b_pix_q.value);
    endcase
  end

  // output register
  logic c_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (c_free) begin
      c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_free && b_valid_q) begin
      red_o          <= color.red;
      green_o        <= color.green;
      blue_o         <= color.blue;
      alpha_o        <= color.alpha;
      last_of_item_o <= b_pix_q.last;
      image_done_o   <= b_pix_q.done;
    end
  end

  assign out_valid_o = c_valid_q;

endmodule

>>> sv/ixpe_palette_ram.sv
// Single-port palette memory, 16-bit entries, registered read data.
module ixpe_palette_ram #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic          re_i,
  input  logic [AW-1:0] addr_i,
  input  logic [15:0]   wdata_i,
  output logic [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];
  logic [15:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> sv/ixpe_sequencer.sv
// Request register and sequencer: splits requests into memory ops and pixels.
module ixpe_sequencer #(
  parameter int unsigned PALETTE_ROWS = 128,
  parameter int unsigned DEPTH        = 2048,
  parameter int unsigned AW           = 11
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             func_i,
  input  logic [15:0]      data_word_i,
  input  logic [10:0]      entry_address_i,
  input  logic             end_of_image_i,
  input  logic [1:0]       mode_i,
  input  logic [6:0]       row_i,
  input  logic             pix_ready_i,
  output logic             pix_valid_o,
  output ixpe_pkg::pix_t   pix_o,
  output logic             mem_we_o,
  output logic             mem_re_o,
  output logic [AW-1:0]    mem_addr_o,
  output logic [15:0]      mem_wdata_o
);
  import ixpe_pkg::*;

  logic        valid_q;
  logic        phase_q;
  logic        func_q;
  logic [15:0] word_q;
  logic [10:0] addr_q;
  logic        eoi_q;

  logic        accept;
  logic        pix_req;
  logic        last;
  logic        fire;
  logic        row_ok;
  logic        addr_ok;
  logic [3:0]  nib;
  logic [11:0] rd_full;
  logic [11:0] wr_full;
  kind_e       kind;

  assign nib     = phase_q ? word_q[7:4] : word_q[3:0];
  assign row_ok  = {2'b00, row_i} < 9'(PALETTE_ROWS);
  assign addr_ok = {2'b00, addr_q} < 13'(DEPTH);
  assign rd_full = {1'b0, row_i, nib};
  assign wr_full = {1'b0, addr_q};

  always_comb begin
    pix_req = 1'b0;
    last    = 1'b1;
    kind    = KIND_DIRECT;
    if (func_q == FUNC_PIXEL) begin
      case (mode_i)
        MODE_RGB555: begin
          pix_req = 1'b1;
        end
        MODE_RAW4: begin
          pix_req = 1'b1;
          last    = phase_q;
          kind    = KIND_RAW;
        end
        MODE_PAL4: begin
          pix_req = 1'b1;
          last    = phase_q;
          kind    = KIND_PALETTE;
        end
        default: begin
          pix_req = 1'b0;
        end
      endcase
    end
  end

  // loads and unused-mode pixels retire without touching the pixel path
  assign fire        = valid_q && (!pix_req || pix_ready_i);
  assign in_ready_o  = !valid_q || (fire && last);
  assign accept      = in_valid_i && in_ready_o;
  assign pix_valid_o = valid_q && pix_req && pix_ready_i;

  always_comb begin
    pix_o.kind  = kind;
    pix_o.value = (kind == KIND_RAW) ? {12'h000, nib} : word_q;
    pix_o.zero  = !row_ok;
    pix_o.last  = last;
    pix_o.done  = last && eoi_q;
  end

  assign mem_we_o    = valid_q && (func_q == FUNC_LOAD) && addr_ok;
  assign mem_re_o    = pix_valid_o && (kind == KIND_PALETTE) && row_ok;
  assign mem_addr_o  = mem_we_o ? wr_full[AW-1:0] : rd_full[AW-1:0];
  assign mem_wdata_o = word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      if (accept) begin
        valid_q <= 1'b1;
        phase_q <= 1'b0;
      end else if (fire) begin
        valid_q <= !last;
        phase_q <= !last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q <= func_i;
      word_q <= data_word_i;
      addr_q <= entry_address_i;
      eoi_q  <= end_of_image_i;
    end
  end

endmodule

>>> sim/tb_indexed_pixel_palette_expander_unit.sv
// Self-checking testbench for the indexed pixel palette expander: directed and random requests.
module tb_indexed_pixel_palette_expander_unit;
  import ixpe_pkg::*;

  localparam int unsigned PALETTE_ROWS = 128;
  localparam int unsigned STORE_DEPTH  = PALETTE_ROWS * ROW_ENTRIES;
  // The package has no name for the fourth mode code; data requests there give no pixel.
  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  // Loads and unused-mode requests give no pixel to wait for, so before reconfiguring
  // the testbench also lets DRAIN_CYCLES pass for them to settle.
  localparam int DRAIN_CYCLES = 8;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASES       = 13;
  localparam int MAX_REPORTS  = 30;

  // One expected or observed pixel, in the block's output widths
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last;
    logic       done;
  } pixel_exp_t;

  // Scoreboard: keeps its own copy of the palette and the two configuration registers,
  // expands each accepted request into the pixels it must produce, and checks
  // observed pixels against the oldest one still waiting.
  class pixel_checker;
    logic [1:0]  pixel_mode;
    logic [6:0]  palette_row;
    logic [15:0] palette [0:STORE_DEPTH-1];
    pixel_exp_t  pending_pixels[$];
    int          errors;
    int          requests;
    int          loads;
    int          pixels_checked;
    int          reg_writes;

    function new();
      pixel_mode     = MODE_RGB555;
      palette_row    = '0;
      errors         = 0;
      requests       = 0;
      loads          = 0;
      pixels_checked = 0;
      reg_writes     = 0;
    endfunction

    function void set_reg(logic idx, logic [6:0] data);
      reg_writes++;
      if (idx == CFG_PIXEL_MODE) pixel_mode = data[1:0];
      else palette_row = data;
    endfunction

    function pixel_exp_t from_rgb555(logic [15:0] v, logic last, logic done);
      pixel_exp_t p;
      logic [15:0] t;
      t       = (v & 16'h001F) << 3;
      p.red   = t[7:0];
      t       = (v & 16'h03E0) >> 2;
      p.green = t[7:0];
      t       = (v & 16'h7C00) >> 7;
      p.blue  = t[7:0];
      p.alpha = (v == 16'h0000) ? 8'h00 : 8'hFF;
      p.last  = last;
      p.done  = done;
      return p;
    endfunction

    function pixel_exp_t from_nibble(logic [3:0] n, logic last, logic done);
      pixel_exp_t p;
      p.red   = {4'h0, n};
      p.green = {4'h0, n};
      p.blue  = {4'h0, n};
      p.alpha = {4'h0, n};
      p.last  = last;
      p.done  = done;
      return p;
    endfunction

    // Entry of the selected row; a row past the store reads as zero
    function logic [15:0] row_entry(logic [3:0] col);
      int unsigned a;
      if (palette_row >= PALETTE_ROWS) return 16'h0000;
      a = palette_row * ROW_ENTRIES + col;
      if (a >= STORE_DEPTH) return 16'h0000;
      return palette[a];
    endfunction

    function void take_request(logic func, logic [15:0] word, logic [10:0] addr, logic eoi);
      logic [3:0] lo;
      logic [3:0] hi;
      requests++;
      // loads never give a pixel, and their end mark means nothing
      if (func == FUNC_LOAD) begin
        loads++;
        if (addr < STORE_DEPTH) palette[addr] = word;
        return;
      end
      lo = word[3:0];
      hi = word[7:4];
      case (pixel_mode)
        MODE_RGB555: pending_pixels.push_back(from_rgb555(word, 1'b1, eoi));
        MODE_RAW4: begin
          pending_pixels.push_back(from_nibble(lo, 1'b0, 1'b0));
          pending_pixels.push_back(from_nibble(hi, 1'b1, eoi));
        end
        MODE_PAL4: begin
          pending_pixels.push_back(from_rgb555(row_entry(lo), 1'b0, 1'b0));
          pending_pixels.push_back(from_rgb555(row_entry(hi), 1'b1, eoi));
        end
        default: ;  // unused mode swallows the request
      endcase
    endfunction

    function void check_pixel(pixel_exp_t got);
      pixel_exp_t want;
      if (pending_pixels.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: unexpected pixel r=%h g=%h b=%h a=%h last=%b done=%b", $time,
                   got.red, got.green, got.blue, got.alpha, got.last, got.done);
        return;
      end
      want = pending_pixels.pop_front();
      pixels_checked++;
      if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
          got.alpha !== want.alpha || got.last !== want.last || got.done !== want.done) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("%0t: pixel mismatch expected r=%h g=%h b=%h a=%h last=%b done=%b, %s",
                   $time, want.red, want.green, want.blue, want.alpha, want.last, want.done,
                   $sformatf("actual r=%h g=%h b=%h a=%h last=%b done=%b",
                             got.red, got.green, got.blue, got.alpha, got.last, got.done));
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = CFG_PIXEL_MODE;
  logic [6:0]  cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic        func_i = FUNC_LOAD;
  logic [15:0] data_word_i = '0;
  logic [10:0] entry_address_i = '0;
  logic        end_of_image_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [7:0]  alpha_o;
  logic        last_of_item_o;
  logic        image_done_o;

  pixel_checker sb;
  int           send_idle_pct = 23;
  int           recv_idle_pct = 53;
  int           cycle_count = 0;
  // Which palette entries hold a value; palette-mode requests only ever read these
  bit           entry_written [0:STORE_DEPTH-1];

  indexed_pixel_palette_expander_unit #(
    .PALETTE_ROWS(PALETTE_ROWS)
  ) u_dut (
    .clk_i,
    .rst_ni,
    .cfg_valid_i,
    .cfg_ready_o,
    .cfg_index_i,
    .cfg_data_i,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .data_word_i,
    .entry_address_i,
    .end_of_image_i,
    .out_valid_o,
    .out_ready_i,
    .red_o,
    .green_o,
    .blue_o,
    .alpha_o,
    .last_of_item_o,
    .image_done_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Pixel monitor: values read here are the ones present just before the edge
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i)
      sb.check_pixel({red_o, green_o, blue_o, alpha_o, last_of_item_o, image_done_o});
  end

  // Watchdog against a hung handshake
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still expected", cycle_count,
               sb.pending_pixels.size());
      $display("simulation failed");
      $finish;
    end
  end

  // Sends one request. Valid is only lowered for an idle gap, so a request that
  // follows straight after an acceptance keeps valid high without a glitch.
  task automatic send_request(input logic func, input logic [15:0] word,
                              input logic [10:0] addr, input logic eoi);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    func_i          <= func;
    data_word_i     <= word;
    entry_address_i <= addr;
    end_of_image_i  <= eoi;
    do @(posedge clk_i); while (!in_ready_o);
    sb.take_request(func, word, addr, eoi);
    if (func == FUNC_LOAD) entry_written[addr] = 1'b1;
  endtask

  task automatic write_reg(input logic idx, input logic [6:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, data);
  endtask

  // Drain all outstanding pixels, let trailing loads settle, then set both registers
  task automatic reconfigure(input logic [1:0] mode, input logic [6:0] row);
    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    write_reg(CFG_PIXEL_MODE, {5'b0, mode});
    write_reg(CFG_PALETTE_ROW, row);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'h8000;
      2: return 16'hFFFF;
      default: return 16'($urandom_range(65535));
    endcase
  endfunction

  // One random request for the current setting. In palette mode data requests
  // only use columns of the current row that were loaded; when the row is still
  // empty a load goes first, into that row with 70 percent chance.
  task automatic random_request(input logic [1:0] mode, input logic [6:0] row);
    int          cols[$];
    logic [3:0]  lo;
    logic [3:0]  hi;
    logic [10:0] addr;
    logic        eoi;
    eoi = ($urandom_range(9) == 0);
    if (mode == MODE_PAL4) begin
      for (int c = 0; c < ROW_ENTRIES; c++)
        if (entry_written[row * ROW_ENTRIES + c]) cols.push_back(c);
      if (cols.size() == 0 || $urandom_range(99) < 25) begin
        if ($urandom_range(99) < 70) addr = 11'(row * ROW_ENTRIES + $urandom_range(15));
        else addr = 11'($urandom_range(STORE_DEPTH - 1));
        send_request(FUNC_LOAD, pick_word(), addr, eoi);
      end else begin
        lo = 4'(cols[$urandom_range(cols.size() - 1)]);
        hi = 4'(cols[$urandom_range(cols.size() - 1)]);
        send_request(FUNC_PIXEL, {8'($urandom_range(255)), hi, lo},
                     11'($urandom_range(2047)), eoi);
      end
    end else if ($urandom_range(99) < 15) begin
      send_request(FUNC_LOAD, pick_word(), 11'($urandom_range(2047)), eoi);
    end else begin
      send_request(FUNC_PIXEL, pick_word(), 11'($urandom_range(2047)), eoi);
    end
  endtask

  initial begin
    logic [1:0] phase_mode [PHASES] = '{MODE_RGB555, MODE_RAW4, MODE_PAL4, MODE_UNUSED,
                                        MODE_PAL4, MODE_RGB555, MODE_RAW4, MODE_PAL4,
                                        MODE_UNUSED, MODE_PAL4, MODE_RAW4, MODE_RGB555,
                                        MODE_PAL4};
    // -1 picks a random row for that phase
    int         phase_row [PHASES] = '{0, 127, 0, -1, 127, -1, -1, -1, -1, -1, 0, -1, -1};
    logic [6:0] row;
    int         count;

    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset setting is direct 16bpp, row 0
    send_request(FUNC_PIXEL, 16'h0000, 11'h000, 1'b0);  // all-zero word, alpha clear
    send_request(FUNC_PIXEL, 16'hFFFF, 11'h7FF, 1'b0);
    send_request(FUNC_PIXEL, 16'h8000, 11'h000, 1'b1);  // only bit 15: black but opaque
    send_request(FUNC_PIXEL, 16'h7C00, 11'h155, 1'b0);
    send_request(FUNC_PIXEL, 16'h03E0, 11'h2AA, 1'b0);
    send_request(FUNC_PIXEL, 16'h001F, 11'h000, 1'b1);
    send_request(FUNC_LOAD, 16'h0000, 11'd0, 1'b1);     // end mark on a load is ignored
    send_request(FUNC_LOAD, 16'hFFFF, 11'd15, 1'b0);
    send_request(FUNC_LOAD, 16'h8000, 11'd5, 1'b0);
    send_request(FUNC_LOAD, 16'h7FFF, 11'd2047, 1'b1);  // top of the store
    send_request(FUNC_LOAD, 16'h1234, 11'd2032, 1'b0);

    reconfigure(MODE_RAW4, 7'd0);
    send_request(FUNC_PIXEL, 16'h0000, 11'h000, 1'b0);
    send_request(FUNC_PIXEL, 16'hFFFF, 11'h7FF, 1'b1);
    send_request(FUNC_PIXEL, 16'h5AA5, 11'h3C3, 1'b0);  // upper byte must be ignored

    reconfigure(MODE_PAL4, 7'd0);
    send_request(FUNC_PIXEL, 16'hFFF0, 11'h000, 1'b0);
    send_request(FUNC_PIXEL, 16'h005F, 11'h7FF, 1'b1);
    send_request(FUNC_PIXEL, 16'h0000, 11'h000, 1'b0);

    reconfigure(MODE_PAL4, 7'd127);
    send_request(FUNC_PIXEL, 16'h000F, 11'h000, 1'b0);
    send_request(FUNC_LOAD, 16'h0001, 11'd2033, 1'b0);
    send_request(FUNC_PIXEL, 16'h0010, 11'h000, 1'b1);  // reads the entry just loaded

    reconfigure(MODE_UNUSED, 7'd127);
    send_request(FUNC_PIXEL, 16'hFFFF, 11'h7FF, 1'b1);  // swallowed
    send_request(FUNC_LOAD, 16'h0420, 11'd2034, 1'b0);
    send_request(FUNC_PIXEL, 16'h0000, 11'h000, 1'b0);

    // Random phases: receiver-heavy idling, then sender-heavy, then none
    for (int p = 0; p < PHASES; p++) begin
      if (p == 5) begin
        send_idle_pct = 53;
        recv_idle_pct = 23;
      end else if (p == 9) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      row = (phase_row[p] < 0) ? 7'($urandom_range(1, 126)) : 7'(phase_row[p]);
      reconfigure(phase_mode[p], row);
      count = (phase_mode[p] == MODE_UNUSED) ? 30 : 177;
      for (int i = 0; i < count; i++) random_request(phase_mode[p], row);
    end

    in_valid_i <= 1'b0;
    while (sb.pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d requests (%0d palette loads) across %0d register writes, all modes",
             sb.requests, sb.loads, sb.reg_writes);
    $display("compared %0d pixels, %0d errors, %0d pixels never seen",
             sb.pixels_checked, sb.errors, sb.pending_pixels.size());
    if (sb.errors == 0 && sb.pending_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
